@@ hdl/rpfal_pkg.sv @@
// Shared types and constants for the record pool allocator.
// Holds the command codes, the sequencer state type and the result word
// handed from the sequencer to the output stage. No dependencies.
package rpfal_pkg;

  localparam int DEF_POOL_RECORDS = 512;
  localparam int KIND_W           = 2;
  localparam int REC_W            = 9;

  localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NEXT   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REINIT = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UNLINK,
    S_LINK1,
    S_LINK2,
    S_NEXT,
    S_SWEEP,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic             load;
    logic             ok;
    logic [REC_W-1:0] handle;
    logic             hv;
    logic [REC_W-1:0] act_first;
    logic             act_nonempty;
  } res_t;

endpackage

@@ hdl/rpfal_ctrl.sv @@
// Link store and sequencer: successor/predecessor memories, the sentinel
// head/tail registers and the state machine that steps each list edit.
// Depends on rpfal_pkg.
module rpfal_ctrl #(
  parameter int POOL_RECORDS = rpfal_pkg::DEF_POOL_RECORDS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [rpfal_pkg::KIND_W-1:0] kind,
  input  logic [rpfal_pkg::REC_W-1:0]  record,
  output logic                         in_ready,
  input  logic                         out_free,
  output rpfal_pkg::res_t              res
);
  import rpfal_pkg::*;

  localparam int AW = (POOL_RECORDS > 1) ? $clog2(POOL_RECORDS) : 1;
  localparam int LW = $clog2(POOL_RECORDS + 2);

  localparam logic [LW-1:0] POOL_CODE = LW'(POOL_RECORDS);
  localparam logic [LW-1:0] FREE_SENT = LW'(POOL_RECORDS);
  localparam logic [LW-1:0] ACT_SENT  = LW'(POOL_RECORDS + 1);
  localparam logic [LW-1:0] LAST_CODE = LW'(POOL_RECORDS - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(POOL_RECORDS - 1);

  // Link memories: one write and one registered read per cycle each.
  logic [LW-1:0] succ_mem [POOL_RECORDS];
  logic [LW-1:0] pred_mem [POOL_RECORDS];
  logic [LW-1:0] succ_rd, pred_rd;

  logic          succ_we, pred_we;
  logic [AW-1:0] succ_waddr, pred_waddr, raddr;
  logic [LW-1:0] succ_wdata, pred_wdata;

  state_t        state, state_next;
  logic [LW-1:0] free_head, free_tail, act_head, act_tail;
  logic [AW-1:0] cur;
  logic [AW-1:0] sweep;
  logic          sweep_report;
  logic          tgt_is_act;
  logic [LW-1:0] s2;
  logic          res_ok, res_hv;
  logic [LW-1:0] res_handle;

  logic [AW+REC_W-1:0] rec_wide;
  logic                rec_in_range;
  logic [AW-1:0]       rec_addr;
  logic [LW-1:0]       cur_code;
  logic [LW-1:0]       lst_sent, lst_head;
  logic [LW-1:0]       hcode;
  logic                ok_eff, hv_eff;
  logic                is_alloc;

  function automatic logic is_rec(input logic [LW-1:0] c);
    return c < POOL_CODE;
  endfunction

  function automatic logic [REC_W-1:0] low_bits(input logic [LW-1:0] c);
    logic [LW+REC_W-1:0] w;
    w = (LW+REC_W)'(c);
    return w[REC_W-1:0];
  endfunction

  assign rec_wide     = (AW+REC_W)'(record);
  assign rec_in_range = rec_wide < (AW+REC_W)'(POOL_RECORDS);
  assign rec_addr     = rec_wide[AW-1:0];
  assign cur_code     = LW'(cur);
  assign lst_sent     = tgt_is_act ? ACT_SENT : FREE_SENT;
  assign lst_head     = tgt_is_act ? act_head : free_head;
  assign is_alloc     = (kind == KIND_ALLOC);

  always_ff @(posedge clk) begin
    if (succ_we) begin
      succ_mem[succ_waddr] <= succ_wdata;
    end
    if (pred_we) begin
      pred_mem[pred_waddr] <= pred_wdata;
    end
    succ_rd <= succ_mem[raddr];
    pred_rd <= pred_mem[raddr];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (kind)
            KIND_ALLOC:  state_next = is_rec(free_head) ? S_UNLINK : S_REPORT;
            KIND_FREE:   state_next = rec_in_range ? S_UNLINK : S_REPORT;
            KIND_NEXT:   state_next = S_NEXT;
            KIND_REINIT: state_next = S_SWEEP;
          endcase
        end
      end
      S_UNLINK: state_next = S_LINK1;
      S_LINK1:  state_next = S_LINK2;
      S_LINK2, S_NEXT, S_REPORT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (sweep == LAST_ADDR) begin
          state_next = sweep_report ? S_REPORT : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory ports and result
  always_comb begin
    in_ready   = 1'b0;
    raddr      = cur;
    succ_we    = 1'b0;
    succ_waddr = cur;
    succ_wdata = succ_rd;
    pred_we    = 1'b0;
    pred_waddr = cur;
    pred_wdata = pred_rd;
    res.load   = 1'b0;
    ok_eff     = res_ok;
    hv_eff     = res_hv;
    hcode      = res_handle;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        raddr    = is_alloc ? free_head[AW-1:0] : rec_addr;
      end
      S_UNLINK: begin
        // bridge the neighbors around the record being taken out
        if (is_rec(succ_rd)) begin
          pred_we    = 1'b1;
          pred_waddr = succ_rd[AW-1:0];
          pred_wdata = pred_rd;
        end
        if (is_rec(pred_rd)) begin
          succ_we    = 1'b1;
          succ_waddr = pred_rd[AW-1:0];
          succ_wdata = succ_rd;
        end
      end
      S_LINK1: begin
        succ_we    = 1'b1;
        succ_wdata = lst_head;
        pred_we    = 1'b1;
        pred_wdata = lst_sent;
      end
      S_LINK2: begin
        // rewrites on a stall carry the same value
        if (is_rec(s2)) begin
          pred_we    = 1'b1;
          pred_waddr = s2[AW-1:0];
          pred_wdata = cur_code;
        end
        res.load = out_free;
      end
      S_NEXT: begin
        ok_eff   = res_ok && is_rec(succ_rd);
        hv_eff   = ok_eff;
        hcode    = succ_rd;
        res.load = out_free;
      end
      S_SWEEP: begin
        succ_we    = 1'b1;
        succ_waddr = sweep;
        succ_wdata = (sweep == LAST_ADDR) ? FREE_SENT : LW'(sweep) + LW'(1);
        pred_we    = 1'b1;
        pred_waddr = sweep;
        pred_wdata = (sweep == '0) ? FREE_SENT : LW'(sweep) - LW'(1);
      end
      S_REPORT: res.load = out_free;
      default: ;
    endcase
    res.ok           = ok_eff;
    res.hv           = hv_eff;
    res.handle       = hv_eff ? low_bits(hcode) : '0;
    res.act_nonempty = is_rec(act_head);
    res.act_first    = is_rec(act_head) ? low_bits(act_head) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      sweep        <= '0;
      sweep_report <= 1'b0;
      free_head    <= '0;
      free_tail    <= LAST_CODE;
      act_head     <= ACT_SENT;
      act_tail     <= ACT_SENT;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur          <= is_alloc ? free_head[AW-1:0] : rec_addr;
            tgt_is_act   <= is_alloc;
            res_handle   <= free_head;
            res_hv       <= is_alloc && is_rec(free_head);
            res_ok       <= is_alloc ? is_rec(free_head) :
                            ((kind == KIND_REINIT) || rec_in_range);
            sweep        <= '0;
            sweep_report <= (kind == KIND_REINIT);
          end
        end
        S_UNLINK: begin
          if (succ_rd == FREE_SENT) free_tail <= pred_rd;
          if (succ_rd == ACT_SENT)  act_tail  <= pred_rd;
          if (pred_rd == FREE_SENT) free_head <= succ_rd;
          if (pred_rd == ACT_SENT)  act_head  <= succ_rd;
        end
        S_LINK1: begin
          if (tgt_is_act) begin
            act_head <= cur_code;
          end else begin
            free_head <= cur_code;
          end
          s2 <= lst_head;
        end
        S_LINK2: begin
          if (s2 == FREE_SENT) free_tail <= cur_code;
          if (s2 == ACT_SENT)  act_tail  <= cur_code;
        end
        S_SWEEP: begin
          sweep <= sweep + AW'(1);
          if (sweep == LAST_ADDR) begin
            free_head <= '0;
            free_tail <= LAST_CODE;
            act_head  <= ACT_SENT;
            act_tail  <= ACT_SENT;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_load_state: assert property (@(posedge clk) disable iff (rst)
    res.load |-> (state == S_LINK2 || state == S_NEXT || state == S_REPORT))
    else $error("result word issued outside a reporting state");

  a_hv_implies_ok: assert property (@(posedge clk) disable iff (rst)
    res.load |-> (res.ok || !res.hv))
    else $error("handle flagged valid on a failed command");

  a_free_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((free_head == FREE_SENT) == (free_tail == FREE_SENT)))
    else $error("free list head and tail disagree on emptiness");

  a_act_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((act_head == ACT_SENT) == (act_tail == ACT_SENT)))
    else $error("active list head and tail disagree on emptiness");

  a_alloc_links: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINK2 && tgt_is_act) |-> is_rec(act_head))
    else $error("active list empty right after an alloc");
`endif

endmodule

@@ hdl/record_pool_free_active_lists.sv @@
// Top level of the record pool allocator: input handshake into the
// sequencer and a registered output word. Depends on rpfal_pkg, rpfal_ctrl.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | kind, record
//   out     | output    | out_valid / out_ready| done_ok, handle, handle_valid,
//           |           |                      | active_first, active_nonempty
//
// Alloc and free step through unlink and two link-memory steps, the last of
// which also reports; next and a failed alloc or free go straight to report;
// reinitialize rewrites one link-memory entry per cycle, then reports.
// After reset the link memories are rebuilt, one entry per cycle, before
// in_ready rises.
// The output register frees the sequencer; a held result stalls only the
// final report step of the following word.
module record_pool_free_active_lists #(
  parameter int POOL_RECORDS = rpfal_pkg::DEF_POOL_RECORDS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rpfal_pkg::KIND_W-1:0] kind,
  input  logic [rpfal_pkg::REC_W-1:0]  record,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         done_ok,
  output logic [rpfal_pkg::REC_W-1:0]  handle,
  output logic                         handle_valid,
  output logic [rpfal_pkg::REC_W-1:0]  active_first,
  output logic                         active_nonempty
);
  import rpfal_pkg::*;

  res_t res;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  rpfal_ctrl #(
    .POOL_RECORDS(POOL_RECORDS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .record   (record),
    .in_ready (in_ready),
    .out_free (out_free),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // hold the word until taken
  always_ff @(posedge clk) begin
    if (res.load) begin
      done_ok         <= res.ok;
      handle          <= res.handle;
      handle_valid    <= res.hv;
      active_first    <= res.act_first;
      active_nonempty <= res.act_nonempty;
    end
  end

endmodule

@@ test/record_pool_free_active_lists_tb.sv @@
// Testbench for record_pool_free_active_lists: drives alloc, free, next and
// reinitialize words and checks every result against a local list model.
// Depends on rpfal_pkg and the record_pool_free_active_lists RTL.
module record_pool_free_active_lists_tb;
  import rpfal_pkg::*;

  localparam int POOL           = DEF_POOL_RECORDS;
  localparam int FREE_END       = POOL;
  localparam int ACT_END        = POOL + 1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RECENT_MAX     = 32;

  typedef struct packed {
    logic             ok;
    logic [REC_W-1:0] hnd;
    logic             hnd_valid;
    logic [REC_W-1:0] act_first;
    logic             act_any;
  } pool_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [KIND_W-1:0] kind = KIND_ALLOC;
  logic [REC_W-1:0]  record = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              done_ok;
  logic [REC_W-1:0]  handle;
  logic              handle_valid;
  logic [REC_W-1:0]  active_first;
  logic              active_nonempty;

  // List model: entries POOL and POOL+1 hold the free and active sentinels.
  int               link_next [POOL+2];
  int               link_prev [POOL+2];
  bit               on_list [POOL];
  pool_result_t     expected_words[$];
  logic [REC_W-1:0] recent_allocs[$];
  pool_result_t     seen_word;
  int               error_count = 0;
  int               stall_cycles = 0;
  bit               no_idle = 1'b0;
  bit               calm = 1'b0;

  record_pool_free_active_lists DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .record          (record),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .done_ok         (done_ok),
    .handle          (handle),
    .handle_valid    (handle_valid),
    .active_first    (active_first),
    .active_nonempty (active_nonempty)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void pool_rebuild();
    for (int i = 0; i < POOL; i++) begin
      link_next[i] = (i + 1 < POOL) ? i + 1 : FREE_END;
      link_prev[i] = (i == 0) ? FREE_END : i - 1;
      on_list[i]   = 1'b1;
    end
    link_next[FREE_END] = 0;
    link_prev[FREE_END] = POOL - 1;
    link_next[ACT_END]  = ACT_END;
    link_prev[ACT_END]  = ACT_END;
  endfunction

  function automatic void chain_cut(int rec);
    int p;
    int s;
    p = link_prev[rec];
    s = link_next[rec];
    link_prev[s]  = p;
    link_next[p]  = s;
    link_next[rec] = 0;
    link_prev[rec] = 0;
    on_list[rec]   = 1'b0;
  endfunction

  function automatic void chain_insert(int at, int rec);
    int s;
    s = link_next[at];
    link_next[at]  = rec;
    link_next[rec] = s;
    link_prev[rec] = at;
    link_prev[s]   = rec;
    on_list[rec]   = 1'b1;
  endfunction

  function automatic pool_result_t predict_word(logic [KIND_W-1:0] k, logic [REC_W-1:0] r);
    pool_result_t res;
    int h;
    int s;
    int ri;
    res = '0;
    ri  = int'(r);
    case (k)
      KIND_ALLOC: begin
        h = link_next[FREE_END];
        if (h < POOL) begin
          chain_cut(h);
          chain_insert(ACT_END, h);
          res.ok        = 1'b1;
          res.hnd       = REC_W'(h);
          res.hnd_valid = 1'b1;
        end
      end
      KIND_FREE: begin
        if (ri < POOL && on_list[ri]) begin
          chain_cut(ri);
          chain_insert(FREE_END, ri);
          res.ok = 1'b1;
        end
      end
      KIND_NEXT: begin
        if (ri < POOL && on_list[ri]) begin
          s = link_next[ri];
          // a sentinel successor means the end of either list
          if (s < POOL) begin
            res.ok        = 1'b1;
            res.hnd       = REC_W'(s);
            res.hnd_valid = 1'b1;
          end
        end
      end
      default: begin
        pool_rebuild();
        res.ok = 1'b1;
      end
    endcase
    h = link_next[ACT_END];
    if (h < POOL) begin
      res.act_first = REC_W'(h);
      res.act_any   = 1'b1;
    end
    return res;
  endfunction

  // Favor records that were handed out lately so frees hit the active list.
  function automatic logic [REC_W-1:0] pick_record();
    if (recent_allocs.size() != 0 && $urandom_range(0, 1) == 0)
      return recent_allocs[$urandom_range(0, recent_allocs.size() - 1)];
    return REC_W'($urandom_range(0, (1 << REC_W) - 1));
  endfunction

  task automatic send_word(input logic [KIND_W-1:0] k, input logic [REC_W-1:0] r,
                           output pool_result_t res);
    if (!no_idle && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    record   <= r;
    do @(posedge clk); while (!in_ready);
    res = predict_word(k, r);
    expected_words.push_back(res);
    if (k == KIND_ALLOC && res.hnd_valid) begin
      recent_allocs.push_back(res.hnd);
      if (recent_allocs.size() > RECENT_MAX) void'(recent_allocs.pop_front());
    end
  endtask

  task automatic run_mix(input int n, input int w_alloc, input int w_free,
                         input int w_reinit);
    pool_result_t     res;
    int               sent;
    int               sel;
    logic [REC_W-1:0] at;
    sent = 0;
    while (sent < n) begin
      sel = $urandom_range(0, 99);
      if (sel < w_reinit) begin
        send_word(KIND_REINIT, pick_record(), res);
        sent++;
      end else if (sel < w_reinit + w_alloc) begin
        send_word(KIND_ALLOC, pick_record(), res);
        sent++;
      end else if (sel < w_reinit + w_alloc + w_free) begin
        send_word(KIND_FREE, pick_record(), res);
        sent++;
      end else if ($urandom_range(0, 1) == 0) begin
        send_word(KIND_NEXT, pick_record(), res);
        sent++;
      end else begin
        // walk along a list by feeding each successor back in
        at = pick_record();
        for (int i = $urandom_range(2, 8); i > 0 && sent < n; i--) begin
          send_word(KIND_NEXT, at, res);
          sent++;
          if (!res.hnd_valid) break;
          at = res.hnd;
        end
      end
    end
  endtask

  task automatic test_directed();
    pool_result_t res;
    send_word(KIND_NEXT, 9'd0, res);
    send_word(KIND_NEXT, 9'd511, res);
    send_word(KIND_ALLOC, 9'd0, res);
    send_word(KIND_ALLOC, 9'd0, res);
    send_word(KIND_ALLOC, 9'd0, res);
    send_word(KIND_ALLOC, 9'd0, res);
    send_word(KIND_NEXT, 9'd3, res);
    send_word(KIND_NEXT, 9'd0, res);
    send_word(KIND_FREE, 9'd1, res);
    send_word(KIND_FREE, 9'd511, res);
    send_word(KIND_NEXT, 9'd510, res);
    send_word(KIND_NEXT, 9'd511, res);
    send_word(KIND_FREE, 9'd0, res);
    send_word(KIND_FREE, 9'd3, res);
    send_word(KIND_FREE, 9'd2, res);
    send_word(KIND_ALLOC, 9'h1FF, res);
    send_word(KIND_FREE, res.hnd, res);
    send_word(KIND_REINIT, 9'h155, res);
    send_word(KIND_NEXT, 9'h0AA, res);
    send_word(KIND_ALLOC, 9'h155, res);
    send_word(KIND_NEXT, 9'h000, res);
    send_word(KIND_FREE, 9'h000, res);
    send_word(KIND_REINIT, 9'h000, res);
  endtask

  // Mostly allocs, enough to run the free list dry and keep hitting it.
  task automatic test_fill_pool();
    run_mix(700, 88, 4, 0);
  endtask

  task automatic test_drain_pool();
    run_mix(400, 10, 70, 0);
  endtask

  task automatic test_random_mix();
    run_mix(600, 33, 30, 2);
  endtask

  task automatic test_full_rate();
    no_idle = 1'b1;
    run_mix(250, 35, 30, 1);
  endtask

  initial begin
    forever begin
      repeat ($urandom_range(50, 300)) @(posedge clk);
      calm <= ~calm;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!no_idle && !calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_word = {done_ok, handle, handle_valid, active_first, active_nonempty};
      if (expected_words.size() == 0) begin
        if (error_count < 10)
          $display("unexpected result word: ok=%0b handle=%0d hv=%0b first=%0d any=%0b",
                   seen_word.ok, seen_word.hnd, seen_word.hnd_valid,
                   seen_word.act_first, seen_word.act_any);
        error_count++;
      end else begin
        if (seen_word.ok !== expected_words[0].ok ||
            seen_word.hnd !== expected_words[0].hnd ||
            seen_word.hnd_valid !== expected_words[0].hnd_valid ||
            seen_word.act_first !== expected_words[0].act_first ||
            seen_word.act_any !== expected_words[0].act_any) begin
          if (error_count < 10)
            $display("mismatch: expected ok=%0b handle=%0d hv=%0b first=%0d any=%0b, %s",
                     expected_words[0].ok, expected_words[0].hnd,
                     expected_words[0].hnd_valid, expected_words[0].act_first,
                     expected_words[0].act_any, "got:");
          if (error_count < 10)
            $display("          actual   ok=%0b handle=%0d hv=%0b first=%0d any=%0b",
                     seen_word.ok, seen_word.hnd, seen_word.hnd_valid,
                     seen_word.act_first, seen_word.act_any);
          error_count++;
        end
        void'(expected_words.pop_front());
      end
    end
  end

  // Count cycles with no word moving on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    pool_rebuild();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_pool();
    test_drain_pool();
    test_random_mix();
    test_full_rate();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
hdl/rpfal_pkg.sv
hdl/rpfal_ctrl.sv
hdl/record_pool_free_active_lists.sv
test/record_pool_free_active_lists_tb.sv
